// ===== hw/rtl/crpe_pkg.sv =====
// shared types and constants for the catmull-rom path evaluator
// used by crpe_axis and catmull_rom_path_eval_unit; depends on nothing
package crpe_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int COORD_W    = 32;
  localparam int WORD_W     = 3 * COORD_W;
  localparam int T_W        = 17;
  localparam int FRAC_W     = 16;
  localparam int CNT_W      = 7;
  localparam int HW         = 40;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = CNT_W;
  localparam int IDX_W      = 6;

  localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_W);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_COUNT = 1'b0,
    REG_CLOSED_PATH = 1'b1
  } cfg_reg_t;

  // register loads of the cubic datapath, one per stage
  typedef struct packed {
    logic coef;
    logic h1;
    logic h2;
    logic h3;
    logic res;
  } axis_ld_t;

endpackage

// ===== hw/rtl/catmull_rom_path_eval_unit.sv =====
// top level of the catmull-rom path evaluator: command pipeline, point store, three axes
// depends on crpe_pkg, crpe_ram, crpe_axis
//
// usage:
//   cfg_we/cfg_index/cfg_data write point_count (index 0) and closed_path (index 1);
//   write them only while no evaluation is in flight.
//   command channel (cmd_valid/cmd_stall): a beat with command = write stores
//   point_x/y/z in slot point_index; a beat with command = evaluate samples the
//   curve at param_t (q1.16, clamped to 1.0) and yields one beat on pos_*.
//   result channel (pos_valid/pos_stall) carries pos_x/y/z in q16.16, saturated.
// timing:
//   nine register stages: input, segment scale, neighbor index, store read,
//   coefficients, three horner multiply steps, saturation. an evaluate passes
//   through them in that order to pos_valid; one beat per cycle sustained while pos_stall is low.
//   writes land in the store at the read stage, so order against evaluates holds.
// reset: clears valid bits and both registers; stored points are undefined until written.
// stall: each stage moves up into a free slot, so bubbles close up behind a stalled
//   result; cmd_stall rises once all nine stages hold a beat and pos_stall is high.
module catmull_rom_path_eval_unit #(
  parameter int MAX_POINTS = crpe_pkg::MAX_POINTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [crpe_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [crpe_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                   cmd_valid,
  output logic                                   cmd_stall,
  input  logic                                   command,
  input  logic [crpe_pkg::IDX_W-1:0]             point_index,
  input  logic signed [crpe_pkg::COORD_W-1:0]    point_x,
  input  logic signed [crpe_pkg::COORD_W-1:0]    point_y,
  input  logic signed [crpe_pkg::COORD_W-1:0]    point_z,
  input  logic [crpe_pkg::T_W-1:0]               param_t,
  output logic                                   pos_valid,
  input  logic                                   pos_stall,
  output logic signed [crpe_pkg::COORD_W-1:0]    pos_x,
  output logic signed [crpe_pkg::COORD_W-1:0]    pos_y,
  output logic signed [crpe_pkg::COORD_W-1:0]    pos_z
);
  import crpe_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int XW = NW + 1;
  localparam int PW = T_W + NW;

  // configuration
  logic [CNT_W-1:0] point_count;
  logic             closed_path;
  logic [NW-1:0]    n_pts;
  logic [NW-1:0]    n_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      closed_path <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_POINT_COUNT: point_count <= cfg_data[CNT_W-1:0];
        REG_CLOSED_PATH: closed_path <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign n_pts = (32'(point_count) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(point_count);
  assign n_m1  = n_pts - NW'(1);

  // stage flow control
  logic [9:1] vld;
  logic [9:1] rdy;

  always_comb begin
    rdy[9] = !vld[9] || !pos_stall;
    for (int s = 8; s >= 1; s--) begin
      rdy[s] = !vld[s] || rdy[s+1];
    end
  end

  assign cmd_stall = !rdy[1];
  assign pos_valid = vld[9];

  logic s3_is_eval;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= cmd_valid;
      end
      for (int s = 2; s <= 9; s++) begin
        if (rdy[s]) begin
          // writes leave the pipeline once they reach the store
          vld[s] <= (s == 4) ? (vld[3] && s3_is_eval) : vld[s-1];
        end
      end
    end
  end

  // stage 1: input register
  cmd_t              s1_cmd;
  logic [IDX_W-1:0]  s1_widx;
  logic [WORD_W-1:0] s1_wdata;
  logic [T_W-1:0]    s1_t;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_cmd   <= cmd_t'(command);
      s1_widx  <= point_index;
      s1_wdata <= {point_x, point_y, point_z};
      s1_t     <= (param_t > T_ONE) ? T_ONE : param_t;
    end
  end

  // stage 2: scale t by count - 1 into segment and fraction
  logic [PW-1:0]     seg_pos;
  cmd_t              s2_cmd;
  logic [IDX_W-1:0]  s2_widx;
  logic [WORD_W-1:0] s2_wdata;
  logic [NW-1:0]     s2_idx;
  logic [FRAC_W-1:0] s2_f;

  assign seg_pos = PW'(s1_t) * PW'(n_m1);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_cmd   <= s1_cmd;
      s2_widx  <= s1_widx;
      s2_wdata <= s1_wdata;
      s2_idx   <= NW'(seg_pos >> FRAC_W);
      s2_f     <= seg_pos[FRAC_W-1:0];
    end
  end

  // stage 3: neighbor indices and end cases
  logic [XW-1:0] idx_x, n_x, sel_x, i0_x, i1_x, i2_x, i3_x, i3_raw;
  logic          is_zero, is_last;

  always_comb begin
    idx_x   = XW'(s2_idx);
    n_x     = XW'(n_pts);
    is_zero = (n_pts == '0);
    is_last = (n_pts <= NW'(1)) || (idx_x + XW'(1) >= n_x);
    sel_x   = (n_pts <= NW'(1) || closed_path) ? '0 : n_x - XW'(1);
    i1_x    = is_last ? sel_x : idx_x;
    if (idx_x == '0) begin
      i0_x = closed_path ? n_x - XW'(1) : '0;
    end else begin
      i0_x = idx_x - XW'(1);
    end
    i2_x   = idx_x + XW'(1);
    i3_raw = idx_x + XW'(2);
    if (closed_path) begin
      i3_x = (i3_raw == n_x) ? '0 : i3_raw;
    end else begin
      i3_x = (i3_raw >= n_x) ? n_x - XW'(1) : i3_raw;
    end
  end

  cmd_t              s3_cmd;
  logic              s3_zero;
  logic              s3_last;
  logic [FRAC_W-1:0] s3_f;
  logic [AW-1:0]     s3_i0, s3_i1, s3_i2, s3_i3;
  logic              s3_inrange;
  logic [AW-1:0]     s3_waddr;
  logic [WORD_W-1:0] s3_wdata;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_cmd     <= s2_cmd;
      s3_zero    <= is_zero;
      s3_last    <= is_last;
      s3_f       <= s2_f;
      s3_i0      <= AW'(i0_x);
      s3_i1      <= AW'(i1_x);
      s3_i2      <= AW'(i2_x);
      s3_i3      <= AW'(i3_x);
      s3_inrange <= 32'(s2_widx) < 32'(MAX_POINTS);
      s3_waddr   <= AW'(s2_widx);
      s3_wdata   <= s2_wdata;
    end
  end

  assign s3_is_eval = (s3_cmd == CMD_EVAL);

  // stage 4: point store, two copies so four points come out per beat
  logic              ram_we;
  logic [WORD_W-1:0] rd_p0, rd_p1, rd_p2, rd_p3;

  assign ram_we = vld[3] && (s3_cmd == CMD_WRITE) && s3_inrange && rdy[4];

  crpe_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_POINTS)
  ) u_ram_lo (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (s3_waddr),
    .wdata  (s3_wdata),
    .re     (rdy[4]),
    .raddr_a(s3_i0),
    .raddr_b(s3_i1),
    .rdata_a(rd_p0),
    .rdata_b(rd_p1)
  );

  crpe_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_POINTS)
  ) u_ram_hi (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (s3_waddr),
    .wdata  (s3_wdata),
    .re     (rdy[4]),
    .raddr_a(s3_i2),
    .raddr_b(s3_i3),
    .rdata_a(rd_p2),
    .rdata_b(rd_p3)
  );

  logic              s4_zero;
  logic              s4_last;
  logic [FRAC_W-1:0] s4_f;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_zero <= s3_zero;
      s4_last <= s3_last;
      s4_f    <= s3_f;
    end
  end

  // stages 5 to 9: per-axis cubic
  axis_ld_t axis_ld;

  assign axis_ld.coef = rdy[5];
  assign axis_ld.h1   = rdy[6];
  assign axis_ld.h2   = rdy[7];
  assign axis_ld.h3   = rdy[8];
  assign axis_ld.res  = rdy[9];

  crpe_axis u_axis_x (
    .clk (clk),
    .ld  (axis_ld),
    .zero(s4_zero),
    .last(s4_last),
    .f   (s4_f),
    .p0  (rd_p0[3*COORD_W-1:2*COORD_W]),
    .p1  (rd_p1[3*COORD_W-1:2*COORD_W]),
    .p2  (rd_p2[3*COORD_W-1:2*COORD_W]),
    .p3  (rd_p3[3*COORD_W-1:2*COORD_W]),
    .pos (pos_x)
  );

  crpe_axis u_axis_y (
    .clk (clk),
    .ld  (axis_ld),
    .zero(s4_zero),
    .last(s4_last),
    .f   (s4_f),
    .p0  (rd_p0[2*COORD_W-1:COORD_W]),
    .p1  (rd_p1[2*COORD_W-1:COORD_W]),
    .p2  (rd_p2[2*COORD_W-1:COORD_W]),
    .p3  (rd_p3[2*COORD_W-1:COORD_W]),
    .pos (pos_y)
  );

  crpe_axis u_axis_z (
    .clk (clk),
    .ld  (axis_ld),
    .zero(s4_zero),
    .last(s4_last),
    .f   (s4_f),
    .p0  (rd_p0[COORD_W-1:0]),
    .p1  (rd_p1[COORD_W-1:0]),
    .p2  (rd_p2[COORD_W-1:0]),
    .p3  (rd_p3[COORD_W-1:0]),
    .pos (pos_z)
  );

  // the command side only backs up when every stage is full and the result is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> ((&vld) && pos_stall))
    else $error("command stall with a free pipeline slot");

  // store read data must hold while its stage waits
  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    !rdy[4] |=> ((rd_p0 === $past(rd_p0)) && (rd_p1 === $past(rd_p1)) &&
                 (rd_p2 === $past(rd_p2)) && (rd_p3 === $past(rd_p3))))
    else $error("store read data changed during stall");

  // the center point of a segment is always a slot in use
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (vld[3] && s3_is_eval && !s3_zero) |-> (32'(s3_i1) < 32'(n_pts)))
    else $error("segment index beyond point count");

endmodule

// ===== hw/rtl/crpe_ram.sv =====
// generic ram: one write port, two read ports, registered read data
// depends on nothing
module crpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== hw/rtl/crpe_axis.sv =====
// cubic datapath for one coordinate: coefficients, three horner steps, saturation
// depends on crpe_pkg
module crpe_axis (
  input  logic                                clk,
  input  crpe_pkg::axis_ld_t                  ld,
  input  logic                                zero,
  input  logic                                last,
  input  logic [crpe_pkg::FRAC_W-1:0]         f,
  input  logic signed [crpe_pkg::COORD_W-1:0] p0,
  input  logic signed [crpe_pkg::COORD_W-1:0] p1,
  input  logic signed [crpe_pkg::COORD_W-1:0] p2,
  input  logic signed [crpe_pkg::COORD_W-1:0] p3,
  output logic signed [crpe_pkg::COORD_W-1:0] pos
);
  import crpe_pkg::*;

  localparam int MW = HW + FRAC_W + 1;

  logic signed [HW-1:0] e0, e1, e2, e3;
  logic signed [HW-1:0] c_next, b_next, a_next, d_next;
  logic signed [HW-1:0] c5, b5, a5, d5;
  logic [FRAC_W-1:0]    f5, f6, f7;
  logic signed [MW-1:0] m1, m2, m3;
  logic signed [HW-1:0] h1_next, h2_next, h3_next;
  logic signed [HW-1:0] h1, a6, d6;
  logic signed [HW-1:0] h2, d7;
  logic signed [HW-1:0] h3;
  logic signed [HW-1:0] half;
  logic [HW-COORD_W:0]  top_bits;
  logic signed [COORD_W-1:0] pos_next;

  // coefficients; special cases fold into zero terms so the cubic yields p1 or 0
  always_comb begin
    e0 = HW'(p0);
    e1 = HW'(p1);
    e2 = HW'(p2);
    e3 = HW'(p3);
    c_next = e3 - e0 + ((e1 - e2) <<< 1) + (e1 - e2);
    b_next = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    a_next = e2 - e0;
    d_next = e1 <<< 1;
    if (zero) begin
      c_next = '0;
      b_next = '0;
      a_next = '0;
      d_next = '0;
    end else if (last) begin
      c_next = '0;
      b_next = '0;
      a_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.coef) begin
      c5 <= c_next;
      b5 <= b_next;
      a5 <= a_next;
      d5 <= d_next;
      f5 <= f;
    end
  end

  // arithmetic shift right is floor division by a power of two
  assign m1      = MW'(c5) * MW'($signed({1'b0, f5}));
  assign h1_next = HW'(m1 >>> FRAC_W) + b5;

  always_ff @(posedge clk) begin
    if (ld.h1) begin
      h1 <= h1_next;
      a6 <= a5;
      d6 <= d5;
      f6 <= f5;
    end
  end

  assign m2      = MW'(h1) * MW'($signed({1'b0, f6}));
  assign h2_next = HW'(m2 >>> FRAC_W) + a6;

  always_ff @(posedge clk) begin
    if (ld.h2) begin
      h2 <= h2_next;
      d7 <= d6;
      f7 <= f6;
    end
  end

  assign m3      = MW'(h2) * MW'($signed({1'b0, f7}));
  assign h3_next = HW'(m3 >>> FRAC_W) + d7;

  always_ff @(posedge clk) begin
    if (ld.h3) begin
      h3 <= h3_next;
    end
  end

  always_comb begin
    half     = h3 >>> 1;
    top_bits = half[HW-1:COORD_W-1];
    if (top_bits == '0 || top_bits == '1) begin
      pos_next = half[COORD_W-1:0];
    end else if (half[HW-1]) begin
      pos_next = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      pos_next = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ld.res) begin
      pos <= pos_next;
    end
  end

endmodule
